### src/bsic_pkg.sv
// Package for the bounded-step increasing chain block.
// Holds sizes, payload structs, the memory request struct and the sequencer states.
// No dependencies.
package bsic_pkg;

   // Value domain and stored length width
   localparam int VALUE_RANGE = 1024;
   localparam int LENGTH_BITS = 16;

   // Fixed field widths
   localparam int VALUE_W = 11;
   localparam int STEP_W  = 11;
   localparam int OUT_W   = 16;

   // Tree node address and query bound widths
   localparam int NODE_BITS = $clog2(2 * VALUE_RANGE);
   localparam int IDX_BITS  = $clog2(2 * VALUE_RANGE + 1);
   localparam int CMP_BITS  = (IDX_BITS > VALUE_W) ? IDX_BITS : VALUE_W;

   typedef logic [NODE_BITS-1:0]   node_type;
   typedef logic [IDX_BITS-1:0]    idx_type;
   typedef logic [LENGTH_BITS-1:0] len_type;
   typedef logic [CMP_BITS-1:0]    cmp_type;

   localparam len_type  LEN_CAP   = '1;
   localparam node_type NODE_LAST = node_type'(2 * VALUE_RANGE - 1);
   localparam node_type NODE_ROOT = node_type'(1);

   typedef struct packed {
      logic [VALUE_W-1:0] item_value;
      logic               first_item;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] chain_here;
      logic [OUT_W-1:0] best_chain;
   } rsp_type;

   // Tree memory access: one write and one read each cycle
   typedef struct packed {
      logic     we;
      node_type waddr;
      len_type  wdata;
      node_type raddr;
   } mem_req_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_Q_LEFT,
      ST_Q_RIGHT,
      ST_Q_DONE,
      ST_U_READ,
      ST_U_WAIT,
      ST_OUT
   } state_type;

endpackage

### src/bsic_tree_mem.sv
// Range-maximum tree storage: 2*VALUE_RANGE lengths.
// One write port and one registered read port. Uses bsic_pkg.
module bsic_tree_mem (
   input  logic                  clock,
   input  bsic_pkg::mem_req_type mem_req,
   output bsic_pkg::len_type     rd_data
);
   import bsic_pkg::*;

   len_type mem [2 * VALUE_RANGE];
   len_type rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      rd_data_ff <= mem[mem_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/bounded_step_increasing_chain.sv
// Top level of the bounded-step increasing chain block.
// Sequencer and datapath around bsic_tree_mem. Uses bsic_pkg.
//
// For each item the block reports the longest strictly increasing chain ending at
// item_value in which each rise is at most max_step, plus the best length of the
// sequence so far. Lengths live in a range-maximum tree held in one memory with a
// single read port. The range query takes a left and a right step per tree
// level over up to log2(VALUE_RANGE)+1 levels plus one closing step. The update
// walk takes a read and a write step per level over log2(VALUE_RANGE) levels
// plus one closing step. Accept, setup, length and output steps come on top.
// Values outside the domain skip the update walk. req_ready is high only between
// items. The result sits in an output register, so the next item is taken while
// the previous result still waits; an item only stalls in its output cycle while
// that register is full. After reset, and before any item flagged first_item, a
// clearing pass writes zero to all 2*VALUE_RANGE tree entries, one per cycle;
// max_step writes are taken at any time.
module bounded_step_increasing_chain (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  bsic_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output bsic_pkg::rsp_type           rsp_data,
   input  logic                        csr_wr_en,
   input  logic [bsic_pkg::STEP_W-1:0] csr_wr_data
);
   import bsic_pkg::*;

   state_type          state_ff, state_in;
   logic [VALUE_W-1:0] v_ff, v_in;
   logic               held_ff, held_in;
   logic [STEP_W-1:0]  step_ff;
   idx_type            a_ff, a_in, b_ff, b_in;
   len_type            acc_ff, acc_in;
   logic               pend_ff, pend_in;
   node_type           node_ff, node_in;
   len_type            cur_ff, cur_in;
   len_type            best_ff, best_in;
   node_type           clr_ff, clr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   mem_req_type mem_req;
   len_type     rd_data;

   logic    accept;
   cmp_type v_ext, step_ext, vr_ext, hi, lo;
   logic    empty, in_domain;
   node_type leaf;
   len_type here, par, fold;

   bsic_tree_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign accept = req_valid && (state_ff == ST_IDLE);

   // query bounds and leaf address from the held value
   always_comb begin
      v_ext     = cmp_type'(v_ff);
      step_ext  = cmp_type'(step_ff);
      vr_ext    = cmp_type'(VALUE_RANGE);
      hi        = ((v_ext - cmp_type'(1)) > vr_ext) ? vr_ext : (v_ext - cmp_type'(1));
      lo        = (step_ext >= v_ext) ? cmp_type'(1) : (v_ext - step_ext);
      empty     = (v_ext == '0) || (lo > hi);
      in_domain = (v_ext != '0) && (v_ext <= vr_ext);
      leaf      = node_type'(v_ext - cmp_type'(1) + vr_ext);
   end

   // chain length here, parent max, and query fold
   assign here = (acc_ff == LEN_CAP) ? LEN_CAP : (acc_ff + len_type'(1));
   assign par  = (rd_data > cur_ff) ? rd_data : cur_ff;
   assign fold = (pend_ff && (rd_data > acc_ff)) ? rd_data : acc_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == NODE_LAST) state_in = held_ff ? ST_SETUP : ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = req_data.first_item ? ST_CLEAR : ST_SETUP;
         end
         ST_SETUP: begin
            state_in = empty ? ST_Q_DONE : ST_Q_LEFT;
         end
         ST_Q_LEFT: begin
            state_in = (a_ff < b_ff) ? ST_Q_RIGHT : ST_Q_DONE;
         end
         ST_Q_RIGHT: begin
            state_in = ST_Q_LEFT;
         end
         ST_Q_DONE: begin
            state_in = in_domain ? ST_U_READ : ST_OUT;
         end
         ST_U_READ: begin
            state_in = (node_ff > NODE_ROOT) ? ST_U_WAIT : ST_OUT;
         end
         ST_U_WAIT: begin
            state_in = ST_U_READ;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // datapath and memory control
   always_comb begin
      req_ready     = 1'b0;
      mem_req.we    = 1'b0;
      mem_req.waddr = clr_ff;
      mem_req.wdata = '0;
      mem_req.raddr = node_type'(a_ff);
      v_in          = v_ff;
      held_in       = held_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      acc_in        = fold;
      pend_in       = 1'b0;
      node_in       = node_ff;
      cur_in        = cur_ff;
      best_in       = best_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = clr_ff;
            mem_req.wdata = '0;
            clr_in        = clr_ff + node_type'(1);
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               v_in    = req_data.item_value;
               held_in = 1'b1;
               if (req_data.first_item) begin
                  best_in = '0;
                  clr_in  = '0;
               end
            end
         end
         ST_SETUP: begin
            acc_in = '0;
            a_in   = idx_type'(lo - cmp_type'(1) + vr_ext);
            b_in   = idx_type'(hi + vr_ext);
         end
         ST_Q_LEFT: begin
            // left bound is a right child: take it and step past it
            if ((a_ff < b_ff) && a_ff[0]) begin
               mem_req.raddr = node_type'(a_ff);
               pend_in       = 1'b1;
               a_in          = a_ff + idx_type'(1);
            end
         end
         ST_Q_RIGHT: begin
            // right bound is odd: take the node just below it
            if (b_ff[0]) begin
               mem_req.raddr = node_type'(b_ff - idx_type'(1));
               pend_in       = 1'b1;
            end
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
         end
         ST_Q_DONE: begin
            best_in = (here > best_ff) ? here : best_ff;
            if (in_domain) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = leaf;
               mem_req.wdata = here;
               node_in       = leaf;
               cur_in        = here;
            end
         end
         ST_U_READ: begin
            mem_req.raddr = node_ff ^ node_type'(1);
         end
         ST_U_WAIT: begin
            // parent takes the max of the updated child and its sibling
            mem_req.we    = 1'b1;
            mem_req.waddr = node_ff >> 1;
            mem_req.wdata = par;
            cur_in        = par;
            node_in       = node_ff >> 1;
         end
         ST_OUT: begin
            // load the result only once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_in.chain_here = OUT_W'(here);
               rsp_in.best_chain = OUT_W'(best_ff);
               held_in           = 1'b0;
            end
         end
         default: begin
            clr_in = '0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         held_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         best_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= STEP_W'(1);
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         pend_ff      <= pend_in;
         best_ff      <= best_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) step_ff <= csr_wr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      node_ff <= node_in;
      cur_ff  <= cur_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### tb/sv/tb_bounded_step_increasing_chain.sv
`timescale 1ns / 1ps
// Testbench for bounded_step_increasing_chain: directed and random item streams
// checked against an in-bench chain-length predictor. Depends on bsic_pkg and the RTL.
module tb_bounded_step_increasing_chain;
   import bsic_pkg::*;

   localparam int RANDOM_ITEMS = 1780;
   localparam int ITEM_LATENCY = 60;
   localparam int DRAIN_LIMIT  = 50000;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int REPORT_MAX   = 10;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_ready;
   req_type             req_data    = '0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   rsp_type             rsp_data;
   logic                csr_wr_en   = 1'b0;
   logic [STEP_W-1:0]   csr_wr_data = '0;

   // Predictor state: chain length per value, best length, current step limit
   len_type             chain_len [1:VALUE_RANGE];
   len_type             best_len;
   logic [STEP_W-1:0]   step_limit;
   rsp_type             expected_rsp [$];

   int                  error_count;
   int                  cycle_count;
   bit                  req_live;
   int                  burst_left;
   int                  send_gap_max;
   int                  rsp_stall_max;
   int                  ready_hold;

   bounded_step_increasing_chain u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // Predict one result and update the stored chain lengths
   function automatic rsp_type predict_chain(req_type item);
      longint  v;
      longint  lo;
      longint  hi;
      longint  prev;
      longint  here;
      rsp_type r;
      v = item.item_value;
      if (item.first_item) begin
         foreach (chain_len[i]) chain_len[i] = '0;
         best_len = '0;
      end
      lo = v - longint'(step_limit);
      hi = v - 1;
      if (lo < 1) lo = 1;
      if (hi > VALUE_RANGE) hi = VALUE_RANGE;
      prev = 0;
      for (longint i = lo; i <= hi; i++)
         if (chain_len[i] > prev) prev = chain_len[i];
      here = prev + 1;
      if (here > longint'(LEN_CAP)) here = LEN_CAP;
      // out-of-domain values are answered but not stored
      if (v >= 1 && v <= VALUE_RANGE) chain_len[v] = len_type'(here);
      if (len_type'(here) > best_len) best_len = len_type'(here);
      r.chain_here = OUT_W'(here);
      r.best_chain = OUT_W'(best_len);
      return r;
   endfunction

   function automatic req_type make_req(int v, bit clr);
      req_type item;
      item.item_value = VALUE_W'(v);
      item.first_item = clr;
      return item;
   endfunction

   // Receiver stall pattern: alternating ready/stall windows of random length
   always @(posedge clock) begin
      if (rsp_stall_max == 0) begin
         rsp_ready <= 1'b1;
      end else if (ready_hold == 0) begin
         rsp_ready  <= ~rsp_ready;
         ready_hold <= $urandom_range(0, rsp_stall_max);
      end else begin
         ready_hold <= ready_hold - 1;
      end
   end

   // Result checker
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_MAX)
               $display("unexpected result: chain %0d best %0d",
                        rsp_data.chain_here, rsp_data.best_chain);
         end else begin
            exp_rsp = expected_rsp.pop_front();
            if (exp_rsp.chain_here !== rsp_data.chain_here ||
                exp_rsp.best_chain !== rsp_data.best_chain) begin
               error_count++;
               if (error_count <= REPORT_MAX)
                  $display("mismatch: expected chain %0d best %0d, got chain %0d best %0d",
                           exp_rsp.chain_here, exp_rsp.best_chain,
                           rsp_data.chain_here, rsp_data.best_chain);
            end
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Present one item and wait for its acceptance; valid stays high afterwards
   task automatic send_item(req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      req_live   = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rsp.push_back(predict_chain(item));
   endtask

   task automatic release_req();
      if (req_live) begin
         req_valid <= 1'b0;
         req_live   = 1'b0;
      end
   endtask

   // Burst pacing on the sender side
   task automatic pace_sender();
      int gap;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 12);
         gap = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
         if (gap > 0) begin
            release_req();
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Wait until every expected result has arrived, then let the block settle
   task automatic drain_results();
      int guard;
      guard = 0;
      release_req();
      @(posedge clock);
      while (expected_rsp.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (ITEM_LATENCY) @(posedge clock);
   endtask

   task automatic write_step(int value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= STEP_W'(value);
      @(posedge clock);
      step_limit = STEP_W'(value);
      csr_wr_en <= 1'b0;
   endtask

   // Reset value of the step limit is one
   task automatic test_default_step();
      send_item(make_req(1, 1'b1));
      send_item(make_req(2, 1'b0));
      send_item(make_req(3, 1'b0));
      send_item(make_req(5, 1'b0));
      send_item(make_req(4, 1'b0));
   endtask

   // Values 0 and above the domain are answered but not stored
   task automatic test_out_of_domain();
      write_step(2047);
      send_item(make_req(0, 1'b1));
      send_item(make_req(2047, 1'b0));
      send_item(make_req(1024, 1'b0));
      send_item(make_req(1025, 1'b0));
      send_item(make_req(1, 1'b0));
   endtask

   // Zero step: empty query range, every chain is one long
   task automatic test_zero_step();
      write_step(0);
      send_item(make_req(10, 1'b1));
      send_item(make_req(11, 1'b0));
      send_item(make_req(12, 1'b0));
   endtask

   // Step equal to VALUE_RANGE: query range clipped at value one and at the domain top
   task automatic test_max_step();
      write_step(1024);
      send_item(make_req(1, 1'b1));
      send_item(make_req(1024, 1'b0));
      send_item(make_req(1025, 1'b0));
      send_item(make_req(2047, 1'b0));
   endtask

   // first_item clears the lengths and the best length mid-stream
   task automatic test_sequence_clear();
      write_step(5);
      send_item(make_req(100, 1'b1));
      send_item(make_req(104, 1'b0));
      send_item(make_req(109, 1'b0));
      send_item(make_req(200, 1'b1));
      send_item(make_req(203, 1'b0));
   endtask

   // Random chains: mostly rising walks, with drops, repeats and noise
   task automatic test_random_sequences();
      int sent;
      int phase;
      int step_val;
      int seq_len;
      int walk;
      int v;
      int pick;
      int rise_cap;
      bit clr;
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         case (phase % 8)
            0:       step_val = 1;
            1:       step_val = $urandom_range(2, 8);
            2:       step_val = $urandom_range(1, 40);
            3:       step_val = 0;
            4:       step_val = 1024;
            5:       step_val = 2047;
            6:       step_val = $urandom_range(0, 2047);
            default: step_val = $urandom_range(9, 200);
         endcase
         write_step(step_val);
         case ($urandom_range(0, 2))
            0:       send_gap_max = 0;
            1:       send_gap_max = 4;
            default: send_gap_max = 60;
         endcase
         case ($urandom_range(0, 2))
            0:       rsp_stall_max = 0;
            1:       rsp_stall_max = 3;
            default: rsp_stall_max = 50;
         endcase
         rise_cap = (step_val == 0) ? 4 : ((step_val > 40) ? 40 : step_val + 1);
         repeat (3) begin
            seq_len = $urandom_range(3, 48);
            walk    = $urandom_range(1, 64);
            for (int k = 0; k < seq_len; k++) begin
               pick = $urandom_range(0, 99);
               if (pick < 70)      walk += $urandom_range(1, rise_cap);
               else if (pick < 85) walk -= $urandom_range(0, 20);
               if (walk > VALUE_RANGE) walk = $urandom_range(1, 32);
               if (walk < 1) walk = 1;
               v = (pick >= 95) ? $urandom_range(0, 2047) : walk;
               if (k == 0) clr = ($urandom_range(0, 7) != 0);
               else        clr = ($urandom_range(0, 199) == 0);
               send_item(make_req(v, clr));
               sent++;
               pace_sender();
            end
         end
         phase++;
      end
   endtask

   initial begin
      error_count   = 0;
      cycle_count   = 0;
      req_live      = 1'b0;
      burst_left    = 1;
      send_gap_max  = 0;
      rsp_stall_max = 0;
      ready_hold    = 0;
      step_limit    = STEP_W'(1);
      best_len      = '0;
      foreach (chain_len[i]) chain_len[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_step();
      test_out_of_domain();
      test_zero_step();
      test_max_step();
      test_sequence_clear();
      test_random_sequences();

      drain_results();
      if (expected_rsp.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
